// ----- rtl/mcv_pkg.sv -----
// ----------------------------------------------------------------------------
// mcv_pkg
// Shared types and constants of the multichannel valid-mode 2D convolution.
// ----------------------------------------------------------------------------
package mcv_pkg;

    // Store geometry
    localparam int MAX_IN_CHANNELS  = 16;
    localparam int MAX_OUT_CHANNELS = 16;
    localparam int MAX_HEIGHT       = 64;
    localparam int MAX_WIDTH        = 64;
    localparam int MAX_KERNEL       = 7;

    localparam int IMG_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int IMG_AW    = $clog2(IMG_DEPTH);
    localparam int WGT_AW    = $clog2(WGT_DEPTH);

    // Field and register widths
    localparam int INDEX_W  = 16;
    localparam int VALUE_W  = 16;
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int SUM_W    = 48;
    localparam int CH_W     = 5;
    localparam int DIM_W    = 7;
    localparam int KER_W    = 3;
    localparam int OC_W     = 4;
    localparam int POS_W    = 6;
    localparam int ICNT_W   = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd5;

    // Request codes
    localparam logic [1:0] FUNC_LOAD_WGT = 2'd0;
    localparam logic [1:0] FUNC_LOAD_PIX = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

    typedef struct packed {
        logic [1:0]                func;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic [OC_W-1:0]           out_channel;
        logic [POS_W-1:0]          out_row;
        logic [POS_W-1:0]          out_col;
    } t_in;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    error;
    } t_out;

    // Saturated geometry as used by the datapath
    typedef struct packed {
        logic [CH_W-1:0]  icn;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] w;
        logic [CH_W-1:0]  ocn;
        logic [KER_W-1:0] kh;
        logic [KER_W-1:0] kw;
    } t_dims;

    // Controller to datapath
    typedef struct packed {
        logic wr_wgt;
        logic wr_pix;
        logic start;
        logic setup1;
        logic setup2;
        logic issue;
        logic row_next;
        logic chan_next;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic err;
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/mcv_cfg.sv -----
// ----------------------------------------------------------------------------
// mcv_cfg
// Geometry registers with saturation to the supported range.
// ----------------------------------------------------------------------------
module mcv_cfg import mcv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_dims                 o_dims
);

    logic [CH_W-1:0]  r_icn;
    logic [DIM_W-1:0] r_h;
    logic [DIM_W-1:0] r_w;
    logic [CH_W-1:0]  r_ocn;
    logic [KER_W-1:0] r_kh;
    logic [KER_W-1:0] r_kw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icn <= CH_W'(1);
            r_h   <= DIM_W'(64);
            r_w   <= DIM_W'(64);
            r_ocn <= CH_W'(1);
            r_kh  <= KER_W'(3);
            r_kw  <= KER_W'(3);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IN_CHANNELS:   r_icn <= i_cfg_data[CH_W-1:0];
                REG_IN_HEIGHT:     r_h   <= i_cfg_data[DIM_W-1:0];
                REG_IN_WIDTH:      r_w   <= i_cfg_data[DIM_W-1:0];
                REG_OUT_CHANNELS:  r_ocn <= i_cfg_data[CH_W-1:0];
                REG_KERNEL_HEIGHT: r_kh  <= i_cfg_data[KER_W-1:0];
                REG_KERNEL_WIDTH:  r_kw  <= i_cfg_data[KER_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero counts as one, anything above the maximum as the maximum
    always_comb begin
        o_dims.icn = (r_icn == '0) ? CH_W'(1) :
                     (r_icn > CH_W'(MAX_IN_CHANNELS)) ? CH_W'(MAX_IN_CHANNELS) : r_icn;
        o_dims.h   = (r_h == '0) ? DIM_W'(1) :
                     (r_h > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_h;
        o_dims.w   = (r_w == '0) ? DIM_W'(1) :
                     (r_w > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_w;
        o_dims.ocn = (r_ocn == '0) ? CH_W'(1) :
                     (r_ocn > CH_W'(MAX_OUT_CHANNELS)) ? CH_W'(MAX_OUT_CHANNELS) : r_ocn;
        o_dims.kh  = (r_kh == '0) ? KER_W'(1) : r_kh;
        o_dims.kw  = (r_kw == '0) ? KER_W'(1) : r_kw;
    end

endmodule

// ----- rtl/mcv_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcv_ctrl
// Sequencer: walks input channel, kernel row and kernel column per request.
// ----------------------------------------------------------------------------
module mcv_ctrl import mcv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    input  t_dims      i_dims,
    input  t_sts       i_sts,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SETUP1 = 6'b000010,
        ST_SETUP2 = 6'b000100,
        ST_RUN    = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [KER_W-1:0]  r_c, n_c;
    logic [KER_W-1:0]  r_r, n_r;
    logic [ICNT_W-1:0] r_ic, n_ic;

    logic last_c, last_r, last_ic, accept;

    assign last_c  = (r_c == i_dims.kw - KER_W'(1));
    assign last_r  = (r_r == i_dims.kh - KER_W'(1));
    assign last_ic = ({1'b0, r_ic} == i_dims.icn - CH_W'(1));

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_c     = r_c;
        n_r     = r_r;
        n_ic    = r_ic;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.wr_wgt = (i_func == FUNC_LOAD_WGT);
                    o_cmd.wr_pix = (i_func == FUNC_LOAD_PIX);
                    if (i_func == FUNC_COMPUTE) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SETUP1;
                    end
                end
            end
            ST_SETUP1: begin
                o_cmd.setup1 = 1'b1;
                n_state      = ST_SETUP2;
            end
            ST_SETUP2: begin
                o_cmd.setup2 = 1'b1;
                n_c  = '0;
                n_r  = '0;
                n_ic = '0;
                n_state = i_sts.err ? ST_DONE : ST_RUN;
            end
            ST_RUN: begin
                o_cmd.issue     = 1'b1;
                o_cmd.row_next  = last_c;
                o_cmd.chan_next = last_c && last_r;
                if (!last_c) begin
                    n_c = r_c + KER_W'(1);
                end else begin
                    n_c = '0;
                    if (!last_r) begin
                        n_r = r_r + KER_W'(1);
                    end else begin
                        n_r = '0;
                        if (last_ic) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_ic = r_ic + ICNT_W'(1);
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_c     <= '0;
            r_r     <= '0;
            r_ic    <= '0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_r     <= n_r;
            r_ic    <= n_ic;
        end
    end

endmodule

// ----- rtl/mcv_dp.sv -----
// ----------------------------------------------------------------------------
// mcv_dp
// Stores, address generation, multiply-accumulate and result register.
// ----------------------------------------------------------------------------
module mcv_dp import mcv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_in_data,
    input  t_dims i_dims,
    input  t_cmd  i_cmd,
    input  logic  i_out_stall,
    output t_sts  o_sts,
    output logic  o_out_valid,
    output t_out  o_out_data
);

    localparam int M1_W = OC_W + CH_W;
    localparam int M2_W = 2 * KER_W;
    localparam int HW_W = 2 * DIM_W;

    logic [VALUE_W-1:0] r_img_mem [IMG_DEPTH];
    logic [VALUE_W-1:0] r_wgt_mem [WGT_DEPTH];

    logic [OC_W-1:0]  r_oc;
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic             r_err;

    logic [M1_W-1:0]   r_m1;
    logic [M2_W-1:0]   r_m2;
    logic [IMG_AW-1:0] r_hw;

    logic [IMG_AW-1:0] r_pa, r_row_base, r_chan_base;
    logic [WGT_AW-1:0] r_wa;
    logic [IMG_AW-1:0] n_chan_base, n_row_base, w_origin;

    logic signed [VALUE_W-1:0] r_pix, r_wgt;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_acc;
    logic                      r_rd_v, r_prod_v;

    logic w_pix_ok, w_wgt_ok;

    assign w_pix_ok = ({1'b0, i_in_data.index} < (INDEX_W+1)'(IMG_DEPTH));
    assign w_wgt_ok = ({1'b0, i_in_data.index} < (INDEX_W+1)'(WGT_DEPTH));

    // Store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pix && w_pix_ok) begin
            r_img_mem[i_in_data.index[IMG_AW-1:0]] <= i_in_data.value;
        end
        if (i_cmd.issue) begin
            r_pix <= r_img_mem[r_pa];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_wgt && w_wgt_ok) begin
            r_wgt_mem[i_in_data.index[WGT_AW-1:0]] <= i_in_data.value;
        end
        if (i_cmd.issue) begin
            r_wgt <= r_wgt_mem[r_wa];
        end
    end

    // Request capture and setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_oc  <= i_in_data.out_channel;
            r_row <= i_in_data.out_row;
            r_col <= i_in_data.out_col;
        end
        if (i_cmd.setup1) begin
            r_err <= ({1'b0, r_oc} >= i_dims.ocn) ||
                     ((8'(r_row) + 8'(i_dims.kh)) > 8'(i_dims.h)) ||
                     ((8'(r_col) + 8'(i_dims.kw)) > 8'(i_dims.w));
            r_m1  <= M1_W'(r_oc * i_dims.icn);
            r_m2  <= M2_W'(i_dims.kh * i_dims.kw);
            r_hw  <= IMG_AW'(HW_W'(i_dims.h * i_dims.w));
        end
    end

    assign w_origin    = IMG_AW'(HW_W'(r_row * i_dims.w) + HW_W'(r_col));
    assign n_chan_base = r_chan_base + r_hw;
    assign n_row_base  = r_row_base + IMG_AW'(i_dims.w);

    // Address walk: step a column, jump to the next row, or to the next channel
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup2) begin
            r_chan_base <= w_origin;
            r_row_base  <= w_origin;
            r_pa        <= w_origin;
            r_wa        <= WGT_AW'(r_m1 * r_m2);
        end else if (i_cmd.issue) begin
            r_wa <= r_wa + WGT_AW'(1);
            if (i_cmd.chan_next) begin
                r_chan_base <= n_chan_base;
                r_row_base  <= n_chan_base;
                r_pa        <= n_chan_base;
            end else if (i_cmd.row_next) begin
                r_row_base <= n_row_base;
                r_pa       <= n_row_base;
            end else begin
                r_pa <= r_pa + IMG_AW'(1);
            end
        end
    end

    // Multiply, then accumulate
    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_prod <= r_pix * r_wgt;
        end
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + SUM_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.issue;
            r_prod_v <= r_rd_v;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_data.sum   <= r_err ? '0 : r_acc;
            o_out_data.error <= r_err;
        end
    end

    assign o_sts.err       = r_err;
    assign o_sts.pipe_busy = r_rd_v || r_prod_v;
    assign o_sts.out_free  = !o_out_valid || !i_out_stall;

endmodule

// ----- rtl/multichannel_conv2d_valid_unit.sv -----
// ----------------------------------------------------------------------------
// multichannel_conv2d_valid_unit
// Valid-mode multichannel 2D cross-correlation, one output sum per compute request.
// ----------------------------------------------------------------------------
//
//  channel | direction | beat accepted when           | payload
//  --------+-----------+------------------------------+------------------------
//  in      | sink      | i_in_valid & !o_in_stall     | t_in (func, index, ...)
//  out     | source    | o_out_valid & !i_out_stall   | t_out (sum, error)
//  cfg     | sink      | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
//  A weight or pixel load is written at its accepting edge; the block is ready
//  again at once. A compute request keeps the input stalled until its result
//  is loaded into the output register; the single multiply-accumulate and the
//  one read port of each store make it walk its products one after another.
//  A request outside the valid area skips the walk: error set, zero sum.
//  Reset (synchronous, active low) restores the geometry defaults and empties
//  the result register; the stores keep their contents and need no clearing.
//  A stalled result waits in the output register while loads keep flowing;
//  only a further compute waits for that register to drain.
//
module multichannel_conv2d_valid_unit import mcv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel
    input  logic                  i_in_valid,
    input  t_in                   i_in_data,
    output logic                  o_in_stall,
    // Result channel
    output logic                  o_out_valid,
    output t_out                  o_out_data,
    input  logic                  i_out_stall,
    // Configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dims w_dims;
    t_cmd  w_cmd;
    t_sts  w_sts;

    // Geometry registers, saturated for use
    mcv_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_dims     (w_dims)
    );

    // Sequencer: loads decode in idle, computes walk channel/row/column
    mcv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_dims     (w_dims),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // Stores, address walk, MAC pipe and result register
    mcv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_dims      (w_dims),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A compute beat closes the input until its result is loaded into the result register
    a_compute_holds_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.func == FUNC_COMPUTE)) |=> o_in_stall)
        else $error("input not held after compute request");

    // Out-of-range positions carry a zero sum
    a_error_zero_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error) |-> (o_out_data.sum == '0))
        else $error("error result with nonzero sum");

    // The MAC pipe is empty whenever new beats are taken
    a_idle_pipe_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_sts.pipe_busy)
        else $error("MAC pipe busy while idle");

endmodule

// ----- bench/multichannel_conv2d_valid_unit_tb.sv -----
// ----------------------------------------------------------------------------
// multichannel_conv2d_valid_unit_tb
// Self-checking bench for the multichannel valid-mode 2D cross-correlation.
// A local predictor mirrors the weight and pixel stores and the geometry
// registers. Each compute beat it accepts queues an expected sum. Directed
// tests cover the defaults, register saturation, kernel bounds and the
// largest image and kernel. Random phases follow, with random geometry,
// load-then-compute sequences, stray loads and unused codes. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module multichannel_conv2d_valid_unit_tb;
    import mcv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Request code the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Random part: about this many beats, and at least this many computes
    localparam int RANDOM_BEATS    = 150;
    localparam int RANDOM_COMPUTES = 20;

    // Loads are written as they are accepted, so a short settle covers any load
    // in flight before a register write. The tail covers one full worst-case compute.
    localparam int SETTLE_CYCLES   = 16;
    localparam int TAIL_CYCLES     = MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL + 16;
    localparam int WATCHDOG_CYCLES = 5000;

    typedef enum {FILL_RANDOM, FILL_MIN, FILL_MAX} t_fill;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in                   i_in_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    multichannel_conv2d_valid_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: store mirrors, written flags and raw register values
    // (held as written, masked to register width; saturation applies on use).
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] pix_mem [IMG_DEPTH];
    logic signed [VALUE_W-1:0] wgt_mem [WGT_DEPTH];
    bit                        pix_set [IMG_DEPTH];
    bit                        wgt_set [WGT_DEPTH];

    logic [CH_W-1:0]  cfg_icn = 5'd1;
    logic [DIM_W-1:0] cfg_h   = 7'd64;
    logic [DIM_W-1:0] cfg_w   = 7'd64;
    logic [CH_W-1:0]  cfg_ocn = 5'd1;
    logic [KER_W-1:0] cfg_kh  = 3'd3;
    logic [KER_W-1:0] cfg_kw  = 3'd3;

    t_out expected_sums[$];
    int   fail_count    = 0;
    int   beats_sent    = 0;
    int   computes_sent = 0;
    int   idle_cycles   = 0;
    int   stall_hold    = 0;
    bit   quiet         = 1'b0;   // when set, neither side idles

    function automatic int sat(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Geometry as the datapath sees it: every register saturated to its range
    function automatic t_dims active_dims();
        t_dims d;
        d.icn = CH_W'(sat(int'(cfg_icn), MAX_IN_CHANNELS));
        d.h   = DIM_W'(sat(int'(cfg_h), MAX_HEIGHT));
        d.w   = DIM_W'(sat(int'(cfg_w), MAX_WIDTH));
        d.ocn = CH_W'(sat(int'(cfg_ocn), MAX_OUT_CHANNELS));
        d.kh  = KER_W'(sat(int'(cfg_kh), MAX_KERNEL));
        d.kw  = KER_W'(sat(int'(cfg_kw), MAX_KERNEL));
        return d;
    endfunction

    function automatic bit position_ok(t_dims d, int oc, int row, int col);
        int h  = int'(d.h);
        int w  = int'(d.w);
        int kh = int'(d.kh);
        int kw = int'(d.kw);
        return kh <= h && kw <= w && oc < int'(d.ocn) && row <= h - kh && col <= w - kw;
    endfunction

    function automatic int pix_addr(t_dims d, int ic, int row, int col);
        return ic * int'(d.h) * int'(d.w) + row * int'(d.w) + col;
    endfunction

    function automatic int wgt_addr(t_dims d, int oc, int ic, int r, int c);
        int kk = int'(d.kh) * int'(d.kw);
        return oc * int'(d.icn) * kk + ic * kk + r * int'(d.kw) + c;
    endfunction

    // Apply one accepted request to the mirrors; return 1 with the expected
    // result when the request is a compute.
    function automatic bit predict_conv_request(input t_in req, output t_out res);
        t_dims  d;
        longint acc;
        res = '0;
        case (req.func)
            FUNC_LOAD_WGT: begin
                // Drop loads past the end of the weight store
                if (int'(req.index) < WGT_DEPTH) begin
                    wgt_mem[req.index] = req.value;
                    wgt_set[req.index] = 1'b1;
                end
                return 1'b0;
            end
            FUNC_LOAD_PIX: begin
                if (int'(req.index) < IMG_DEPTH) begin
                    pix_mem[req.index] = req.value;
                    pix_set[req.index] = 1'b1;
                end
                return 1'b0;
            end
            FUNC_COMPUTE: begin
                d = active_dims();
                if (!position_ok(d, req.out_channel, req.out_row, req.out_col)) begin
                    res.error = 1'b1;
                    return 1'b1;
                end
                acc = 0;
                for (int ic = 0; ic < int'(d.icn); ic++)
                    for (int r = 0; r < int'(d.kh); r++)
                        for (int c = 0; c < int'(d.kw); c++)
                            acc += longint'(pix_mem[pix_addr(d, ic, req.out_row + r,
                                                             req.out_col + c)])
                                 * longint'(wgt_mem[wgt_addr(d, req.out_channel, ic, r, c)]);
                res.sum = acc[SUM_W-1:0];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'sh8000;
        if (r < 20) return 16'sh7FFF;
        if (r < 25) return '0;
        return VALUE_W'($urandom);
    endfunction

    function automatic logic signed [VALUE_W-1:0] fill_value(t_fill kind);
        case (kind)
            FILL_MIN: return 16'sh8000;
            FILL_MAX: return 16'sh7FFF;
            default:  return rand_value();
        endcase
    endfunction

    // Fill every field with noise; callers override what the request uses
    function automatic t_in random_fields();
        t_in r;
        r.func        = 2'($urandom);
        r.index       = INDEX_W'($urandom);
        r.value       = VALUE_W'($urandom);
        r.out_channel = OC_W'($urandom);
        r.out_row     = POS_W'($urandom);
        r.out_col     = POS_W'($urandom);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Entered and left at a falling edge. Valid is left high
    // on exit, so a following call with no gap keeps the beats back to back;
    // anything else that waits lowers it first.
    // ------------------------------------------------------------------
    task automatic send_beat(t_in req);
        int   gap;
        t_out res;
        gap = pick_gap();
        repeat (gap) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (predict_conv_request(req, res)) expected_sums.push_back(res);
        if (req.func != FUNC_UNUSED) beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_load(logic [1:0] func, int addr, logic signed [VALUE_W-1:0] value);
        t_in req;
        req       = random_fields();
        req.func  = func;
        req.index = INDEX_W'(addr);
        req.value = value;
        send_beat(req);
    endtask

    task automatic send_unused();
        t_in req;
        req      = random_fields();
        req.func = FUNC_UNUSED;
        send_beat(req);
    endtask

    // Load every pixel and weight the window reads that is not yet written,
    // or all of them when forced.
    task automatic load_window(t_dims d, int oc, int row, int col, bit force_all,
                               t_fill pix_fill, t_fill wgt_fill);
        int pa;
        int wa;
        for (int ic = 0; ic < int'(d.icn); ic++)
            for (int r = 0; r < int'(d.kh); r++)
                for (int c = 0; c < int'(d.kw); c++) begin
                    pa = pix_addr(d, ic, row + r, col + c);
                    wa = wgt_addr(d, oc, ic, r, c);
                    if (force_all || !pix_set[pa])
                        send_load(FUNC_LOAD_PIX, pa, fill_value(pix_fill));
                    if (force_all || !wgt_set[wa])
                        send_load(FUNC_LOAD_WGT, wa, fill_value(wgt_fill));
                end
    endtask

    // Compute one output point; a valid position gets its window loaded first
    task automatic run_compute(int oc, int row, int col, bit force_all,
                               t_fill pix_fill, t_fill wgt_fill);
        t_dims d;
        t_in   req;
        d = active_dims();
        if (position_ok(d, oc, row, col))
            load_window(d, oc, row, col, force_all, pix_fill, wgt_fill);
        req             = random_fields();
        req.func        = FUNC_COMPUTE;
        req.out_channel = OC_W'(oc);
        req.out_row     = POS_W'(row);
        req.out_col     = POS_W'(col);
        send_beat(req);
        computes_sent++;
    endtask

    // Hold the request side until every expected result is back, then let
    // any trailing load retire.
    task automatic wait_drain(int settle);
        i_in_valid = 1'b0;
        while (expected_sums.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // Drive one register write for a cycle; the caller lowers the enable
    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            REG_IN_CHANNELS:   cfg_icn = data[CH_W-1:0];
            REG_IN_HEIGHT:     cfg_h   = data[DIM_W-1:0];
            REG_IN_WIDTH:      cfg_w   = data[DIM_W-1:0];
            REG_OUT_CHANNELS:  cfg_ocn = data[CH_W-1:0];
            REG_KERNEL_HEIGHT: cfg_kh  = data[KER_W-1:0];
            REG_KERNEL_WIDTH:  cfg_kw  = data[KER_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_geometry(logic [CFG_DATA_W-1:0] icn, logic [CFG_DATA_W-1:0] h,
                                logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] ocn,
                                logic [CFG_DATA_W-1:0] kh, logic [CFG_DATA_W-1:0] kw);
        wait_drain(SETTLE_CYCLES);
        put_reg(REG_IN_CHANNELS, icn);
        put_reg(REG_IN_HEIGHT, h);
        put_reg(REG_IN_WIDTH, w);
        put_reg(REG_OUT_CHANNELS, ocn);
        put_reg(REG_KERNEL_HEIGHT, kh);
        put_reg(REG_KERNEL_WIDTH, kw);
        i_cfg_we = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset geometry: one channel, 64x64 image, 3x3 kernel, one output channel
    task automatic test_reset_defaults();
        run_compute(0, 0, 0, 1'b1, FILL_MIN, FILL_MIN);
        run_compute(0, 61, 61, 1'b1, FILL_MAX, FILL_MIN);
        // Last row and column past the valid area, and a channel too high
        run_compute(0, 62, 0, 1'b0, FILL_RANDOM, FILL_RANDOM);
        run_compute(0, 0, 62, 1'b0, FILL_RANDOM, FILL_RANDOM);
        run_compute(1, 0, 0, 1'b0, FILL_RANDOM, FILL_RANDOM);
        run_compute(15, 63, 63, 1'b0, FILL_RANDOM, FILL_RANDOM);
        send_unused();
        // Weight loads past the store end must leave it untouched
        send_load(FUNC_LOAD_WGT, 16'hFFFF, 16'sh1234);
        send_load(FUNC_LOAD_WGT, WGT_DEPTH, 16'sh4321);
        send_load(FUNC_LOAD_PIX, 16'hFFFF, 16'sh8000);
        run_compute(0, 61, 61, 1'b0, FILL_RANDOM, FILL_RANDOM);
    endtask

    // Zero and oversize register values saturate; upper data bits are dropped
    task automatic test_register_saturation();
        set_geometry(7'h60, 7'd127, 7'd127, 7'd31, 7'h78, 7'd0);
        run_compute(15, 63, 63, 1'b1, FILL_RANDOM, FILL_RANDOM);
        run_compute(15, 0, 0, 1'b1, FILL_MAX, FILL_MAX);
        run_compute(0, 63, 0, 1'b0, FILL_RANDOM, FILL_RANDOM);
        set_geometry(7'h7F, 7'd1, 7'd1, 7'd16, 7'd1, 7'd1);
        run_compute(15, 0, 0, 1'b1, FILL_MAX, FILL_MAX);
        run_compute(0, 0, 0, 1'b1, FILL_MIN, FILL_MIN);
        run_compute(0, 0, 1, 1'b0, FILL_RANDOM, FILL_RANDOM);
    endtask

    // Kernel taller or wider than the image, and a kernel that fits exactly
    task automatic test_kernel_bounds();
        set_geometry(7'd1, 7'd3, 7'd7, 7'd2, 7'd5, 7'd3);
        run_compute(0, 0, 0, 1'b0, FILL_RANDOM, FILL_RANDOM);
        set_geometry(7'd1, 7'd7, 7'd6, 7'd1, 7'd1, 7'd7);
        run_compute(0, 0, 0, 1'b0, FILL_RANDOM, FILL_RANDOM);
        set_geometry(7'd1, 7'd7, 7'd7, 7'd1, 7'd7, 7'd7);
        run_compute(0, 0, 0, 1'b1, FILL_MIN, FILL_MIN);
        run_compute(0, 1, 0, 1'b0, FILL_RANDOM, FILL_RANDOM);
        run_compute(0, 0, 1, 1'b0, FILL_RANDOM, FILL_RANDOM);
    endtask

    // Largest image, kernel and output channel, walked over two input channels
    task automatic test_largest_geometry();
        set_geometry(7'd2, 7'd64, 7'd64, 7'd16, 7'd7, 7'd7);
        run_compute(15, 57, 57, 1'b1, FILL_MIN, FILL_MIN);
        run_compute(15, 58, 57, 1'b0, FILL_RANDOM, FILL_RANDOM);
    endtask

    task automatic random_action();
        t_dims d;
        int    r;
        d = active_dims();
        r = $urandom_range(0, 99);
        if (r < 55 && d.kh <= d.h && d.kw <= d.w) begin
            // Well-formed: load what the window needs, sometimes refresh it
            run_compute($urandom_range(0, int'(d.ocn) - 1),
                        $urandom_range(0, int'(d.h) - int'(d.kh)),
                        $urandom_range(0, int'(d.w) - int'(d.kw)),
                        $urandom_range(0, 3) == 0, FILL_RANDOM, FILL_RANDOM);
        end else if (r < 70) begin
            run_compute($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 63),
                        1'b0, FILL_RANDOM, FILL_RANDOM);
        end else if (r < 80) begin
            send_load(FUNC_LOAD_WGT, $urandom_range(0, 1) ? $urandom_range(0, WGT_DEPTH - 1)
                                                           : int'(INDEX_W'($urandom)),
                      rand_value());
        end else if (r < 94) begin
            send_load(FUNC_LOAD_PIX, int'(INDEX_W'($urandom)), rand_value());
        end else if (r < 98) begin
            send_unused();
        end else begin
            wait_drain(0);
        end
    endtask

    // Random phases: mostly small geometry, sometimes raw register values
    task automatic test_random_traffic();
        int first_beat;
        int first_compute;
        int phase;
        bit raw;
        first_beat    = beats_sent;
        first_compute = computes_sent;
        phase         = 0;
        while (beats_sent - first_beat < RANDOM_BEATS ||
               computes_sent - first_compute < RANDOM_COMPUTES) begin
            raw = phase != 0 && $urandom_range(0, 99) < 15;
            // Raw values keep the kernel field small so the windows stay short
            if (raw)
                set_geometry(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                             {4'($urandom), 3'($urandom_range(0, 2))},
                             {4'($urandom), 3'($urandom_range(0, 2))});
            else
                set_geometry(7'($urandom_range(1, 3)), 7'($urandom_range(1, 10)),
                             7'($urandom_range(1, 10)), 7'($urandom_range(1, 4)),
                             7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)));
            // Every third phase runs with no idling on either side
            quiet = (phase % 3 == 1);
            repeat (raw ? 4 : 10) random_action();
            phase++;
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: stall in random bursts, check every accepted beat
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold = stall_hold - 1;
        end else if (i_out_stall || quiet) begin
            i_out_stall = 1'b0;
            stall_hold  = quiet ? 0 : $urandom_range(0, 15);
        end else begin
            i_out_stall = 1'b1;
            stall_hold  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(10, 40);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_sums.size() == 0) begin
                $display("%0t: result with none expected: sum %0d error %0b",
                         $time, o_out_data.sum, o_out_data.error);
                fail_count++;
            end else begin
                want = expected_sums.pop_front();
                if (o_out_data.sum !== want.sum) begin
                    $display("%0t: sum mismatch: expected %0d, actual %0d",
                             $time, want.sum, o_out_data.sum);
                    fail_count++;
                end
                if (o_out_data.error !== want.error) begin
                    $display("%0t: error flag mismatch: expected %0b, actual %0b",
                             $time, want.error, o_out_data.error);
                    fail_count++;
                end
            end
        end
    end

    // Abort when no beat moves on any port for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_sums.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // Hold reset, then release it on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_register_saturation();
        test_kernel_bounds();
        test_largest_geometry();
        test_random_traffic();

        // Drain, then give a stray result time to show up
        wait_drain(TAIL_CYCLES);
        if (expected_sums.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_sums.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mcv_pkg.sv
rtl/mcv_cfg.sv
rtl/mcv_ctrl.sv
rtl/mcv_dp.sv
rtl/multichannel_conv2d_valid_unit.sv
bench/multichannel_conv2d_valid_unit_tb.sv
